// ----- rtl/core/tmbt_pkg.sv -----
// ----------------------------------------------------------------------------
// tmbt_pkg
// Shared sizes, codes, message layout and index helper of the thread
// mailbox and blocking tracker.
// ----------------------------------------------------------------------------
package tmbt_pkg;

   localparam int THREADS     = 16;
   localparam int INBOX_DEPTH = 16;

   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;         // thread index
   localparam int QW = (INBOX_DEPTH > 1) ? $clog2(INBOX_DEPTH) : 1; // queue slot
   localparam int CW = $clog2(INBOX_DEPTH + 1);                     // queue count
   localparam int SW = $clog2(THREADS + 1);                         // chain steps
   localparam int AW = TW + QW;                                     // store address
   localparam int STORE_DEPTH = 1 << AW;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 3;
   localparam int MSG_W    = 61;

   localparam logic [FUNC_W-1:0] FUNC_PUT    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_NULL   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEADLOCK = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   localparam logic [1:0] REG_LIMIT    = 2'd0;
   localparam logic [1:0] REG_NULL_SRC = 2'd1;
   localparam logic [1:0] REG_NULL_NUM = 2'd2;
   localparam logic [1:0] REG_NULL_KND = 2'd3;

   typedef struct packed {
      logic [3:0]  src;
      logic [15:0] num;
      logic        wants;
      logic [7:0]  kind;
      logic [31:0] payload;
   } msg_type;

   // reduce a 4-bit thread field into the thread range
   function automatic logic [TW-1:0] thr_mod(input logic [3:0] v);
      logic [8:0] r;
      r = 9'(v);
      for (int i = 0; i < 8; i++) begin
         if (r >= 9'(THREADS)) begin
            r = r - 9'(THREADS);
         end
      end
      return TW'(r);
   endfunction

endpackage

// ----- rtl/core/tmbt_req_if.sv -----
// ----------------------------------------------------------------------------
// tmbt_req_if
// Request channel: one mailbox operation per word.
// ----------------------------------------------------------------------------
interface tmbt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [3:0]  sender;
   logic [3:0]  target;
   logic [15:0] message_number;
   logic        wants_reply;
   logic [7:0]  message_kind;
   logic [31:0] payload_handle;

   modport source (
      output valid, func, sender, target, message_number, wants_reply,
             message_kind, payload_handle,
      input  ready
   );
   modport sink (
      input  valid, func, sender, target, message_number, wants_reply,
             message_kind, payload_handle,
      output ready
   );
endinterface

// ----- rtl/core/tmbt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tmbt_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface tmbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        sender_now_blocked;
   logic        target_woken;
   logic        has_message;
   logic [3:0]  out_source;
   logic [15:0] out_number;
   logic        out_wants_reply;
   logic [7:0]  out_kind;
   logic [31:0] out_payload;
   logic        last;

   modport source (
      output valid, status, sender_now_blocked, target_woken, has_message,
             out_source, out_number, out_wants_reply, out_kind, out_payload, last,
      input  ready
   );
   modport sink (
      input  valid, status, sender_now_blocked, target_woken, has_message,
             out_source, out_number, out_wants_reply, out_kind, out_payload, last,
      output ready
   );
endinterface

// ----- rtl/core/tmbt_ram.sv -----
// ----------------------------------------------------------------------------
// tmbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/core/thread_mailbox_block_tracker.sv -----
// ----------------------------------------------------------------------------
// thread_mailbox_block_tracker
// Per-thread mailbox queues with blocking-send tracking and deadlock check.
// ----------------------------------------------------------------------------
// One operation at a time; the request side is ready only when idle.
// Put: look-up, a walk of the target's wait chain when blocking, the decision,
// and a step that marks the sender waiting when it blocks. Get: look-up, store
// read request, read data. Flush: look-up, then per drained word a store read
// and a response slot. Create, null fill: look-up only. The response register holds
// until taken. Reset clears wait state, open bits, queue heads and counts at once.
module thread_mailbox_block_tracker (
   input  logic        clock,
   input  logic        reset,
   tmbt_req_if.sink    req_ch,
   tmbt_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int TW = tmbt_pkg::TW;
   localparam int QW = tmbt_pkg::QW;
   localparam int CW = tmbt_pkg::CW;
   localparam int SW = tmbt_pkg::SW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_CHAIN  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_BLOCK  = 3'd4;
   localparam logic [2:0] S_RDREQ  = 3'd5;
   localparam logic [2:0] S_RDDATA = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   typedef struct packed {
      logic          wait_en;
      logic          open_en;
      logic          queue_en;
      logic [TW-1:0] idx;
      logic          wf;
      logic [TW-1:0] wo;
      logic [15:0]   aw;
      logic          open;
      logic [QW-1:0] head;
      logic [CW-1:0] cnt;
   } thr_wr_type;

   // thread table
   logic          wf_ff   [tmbt_pkg::THREADS];
   logic [TW-1:0] wo_ff   [tmbt_pkg::THREADS];
   logic [15:0]   aw_ff   [tmbt_pkg::THREADS];
   logic          open_ff [tmbt_pkg::THREADS];
   logic [QW-1:0] head_ff [tmbt_pkg::THREADS];
   logic [CW-1:0] cnt_ff  [tmbt_pkg::THREADS];

   logic [2:0]                    state_ff, state_in;
   logic [tmbt_pkg::FUNC_W-1:0]   func_ff;
   logic [TW-1:0]                 s_ff, t_ff;
   tmbt_pkg::msg_type             msg_ff;
   logic [TW-1:0]                 x_ff, x_in;
   logic [SW-1:0]                 steps_ff, steps_in;
   logic                          flush_ff, flush_in;
   logic                          woke_ff, woke_in;

   logic [3:0]  lim_ff;
   logic [3:0]  nsrc_ff;
   logic [15:0] nnum_ff;
   logic [7:0]  nkind_ff;

   logic                            rsp_valid_ff;
   logic [tmbt_pkg::STATUS_W-1:0]   o_status_ff;
   logic                            o_blk_ff, o_woke_ff, o_has_ff, o_last_ff;
   tmbt_pkg::msg_type               o_msg_ff;

   logic                            emit_en;
   logic [tmbt_pkg::STATUS_W-1:0]   emit_status;
   logic                            emit_blk, emit_woke, emit_has, emit_last;
   tmbt_pkg::msg_type               emit_msg;

   thr_wr_type thr_wr;

   logic [TW-1:0] rd_idx;
   logic          rd_wf;
   logic [TW-1:0] rd_wo;
   logic [15:0]   rd_aw;
   logic          rd_open;
   logic [QW-1:0] rd_head;
   logic [CW-1:0] rd_cnt;

   logic                        ram_we;
   logic [tmbt_pkg::AW-1:0]     ram_waddr, ram_raddr;
   tmbt_pkg::msg_type           ram_wdata, ram_rdata;

   logic          req_acc, rsp_acc;
   logic [QW-1:0] tail_slot, head_inc, head_dec;
   logic [9:0]    tail_sum;
   logic          full_q, over_lim, match;
   tmbt_pkg::msg_type null_msg;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_valid_ff && rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // single table read port
   assign rd_idx  = (state_ff == S_CHAIN) ? x_ff : t_ff;
   assign rd_wf   = wf_ff[rd_idx];
   assign rd_wo   = wo_ff[rd_idx];
   assign rd_aw   = aw_ff[rd_idx];
   assign rd_open = open_ff[rd_idx];
   assign rd_head = head_ff[rd_idx];
   assign rd_cnt  = cnt_ff[rd_idx];

   always_comb begin
      tail_sum = 10'(rd_head) + 10'(rd_cnt);
      if (tail_sum >= 10'(tmbt_pkg::INBOX_DEPTH)) begin
         tail_sum = tail_sum - 10'(tmbt_pkg::INBOX_DEPTH);
      end
      tail_slot = QW'(tail_sum);
   end
   assign head_inc = (rd_head == QW'(tmbt_pkg::INBOX_DEPTH - 1)) ? '0 : rd_head + 1'b1;
   assign head_dec = (rd_head == '0) ? QW'(tmbt_pkg::INBOX_DEPTH - 1) : rd_head - 1'b1;
   assign full_q   = 9'(rd_cnt) >= 9'(tmbt_pkg::INBOX_DEPTH);
   assign over_lim = (9'(rd_cnt) >= 9'(lim_ff)) || full_q;
   assign match    = rd_wf && (rd_wo == s_ff) && (rd_aw == msg_ff.num);

   always_comb begin
      null_msg.src     = nsrc_ff;
      null_msg.num     = nnum_ff;
      null_msg.wants   = 1'b0;
      null_msg.kind    = nkind_ff;
      null_msg.payload = '0;
   end

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      steps_in    = steps_ff;
      flush_in    = flush_ff;
      woke_in     = woke_ff;
      emit_en     = 1'b0;
      emit_status = tmbt_pkg::ST_OK;
      emit_blk    = 1'b0;
      emit_woke   = 1'b0;
      emit_has    = 1'b0;
      emit_last   = 1'b0;
      emit_msg    = '0;
      thr_wr      = '0;
      thr_wr.idx  = t_ff;
      thr_wr.wf   = rd_wf;
      thr_wr.wo   = rd_wo;
      thr_wr.aw   = rd_aw;
      thr_wr.head = rd_head;
      thr_wr.cnt  = rd_cnt;
      ram_we      = 1'b0;
      ram_waddr   = {t_ff, tail_slot};
      ram_wdata   = msg_ff;
      ram_raddr   = {t_ff, rd_head};

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            flush_in = (func_ff == tmbt_pkg::FUNC_FLUSH);
            woke_in  = 1'b0;
            case (func_ff)
               tmbt_pkg::FUNC_PUT: begin
                  if (!rd_open) begin
                     emit_en     = 1'b1;
                     emit_status = tmbt_pkg::ST_DISABLED;
                  end else if (msg_ff.wants && (s_ff == t_ff)) begin
                     emit_en     = 1'b1;
                     emit_status = tmbt_pkg::ST_DEADLOCK;
                  end else if (msg_ff.wants && rd_wf) begin
                     x_in     = rd_wo;
                     steps_in = '0;
                     state_in = S_CHAIN;
                  end else begin
                     state_in = S_DECIDE;
                  end
               end
               tmbt_pkg::FUNC_GET: begin
                  if (rd_cnt == '0) begin
                     emit_en     = 1'b1;
                     emit_status = tmbt_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_RDREQ;
                  end
               end
               tmbt_pkg::FUNC_FLUSH: begin
                  thr_wr.open_en = 1'b1;
                  thr_wr.open    = 1'b0;
                  if (rd_cnt == '0) begin
                     emit_en   = 1'b1;
                     emit_last = 1'b1;
                  end else begin
                     state_in = S_RDREQ;
                  end
               end
               tmbt_pkg::FUNC_NULL: begin
                  emit_en = 1'b1;
                  if (!rd_open) begin
                     emit_status = tmbt_pkg::ST_DISABLED;
                  end else if (rd_cnt == '0) begin
                     ram_we          = 1'b1;
                     ram_wdata       = null_msg;
                     thr_wr.queue_en = 1'b1;
                     thr_wr.cnt      = rd_cnt + 1'b1;
                     emit_has        = 1'b1;
                     emit_msg        = null_msg;
                  end
               end
               tmbt_pkg::FUNC_CREATE: begin
                  thr_wr.wait_en  = 1'b1;
                  thr_wr.wf       = 1'b0;
                  thr_wr.wo       = '0;
                  thr_wr.aw       = '0;
                  thr_wr.open_en  = 1'b1;
                  thr_wr.open     = 1'b1;
                  thr_wr.queue_en = 1'b1;
                  thr_wr.head     = '0;
                  thr_wr.cnt      = '0;
                  emit_en         = 1'b1;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_CHAIN: begin
            // follow the wait chain one thread per cycle
            if (rd_wf && (steps_ff < SW'(tmbt_pkg::THREADS))) begin
               x_in     = rd_wo;
               steps_in = steps_ff + 1'b1;
            end else if (rd_wf || (x_ff == s_ff)) begin
               emit_en     = 1'b1;
               emit_status = tmbt_pkg::ST_DEADLOCK;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (match || !over_lim) begin
               thr_wr.queue_en = 1'b1;
               ram_we          = 1'b1;
               if (match) begin
                  // reply goes to the head; drop newest entry if full
                  thr_wr.wait_en = 1'b1;
                  thr_wr.wf      = 1'b0;
                  thr_wr.wo      = '0;
                  thr_wr.head    = head_dec;
                  thr_wr.cnt     = full_q ? CW'(tmbt_pkg::INBOX_DEPTH) : rd_cnt + 1'b1;
                  ram_waddr      = {t_ff, head_dec};
               end else begin
                  thr_wr.cnt = rd_cnt + 1'b1;
               end
               woke_in = match;
               if (msg_ff.wants) begin
                  state_in = S_BLOCK;
               end else begin
                  emit_en   = 1'b1;
                  emit_woke = match;
                  emit_has  = 1'b1;
                  emit_msg  = msg_ff;
               end
            end else begin
               emit_en     = 1'b1;
               emit_status = tmbt_pkg::ST_OVERFLOW;
            end
         end
         S_BLOCK: begin
            thr_wr.idx     = s_ff;
            thr_wr.wait_en = 1'b1;
            thr_wr.wf      = 1'b1;
            thr_wr.wo      = t_ff;
            thr_wr.aw      = msg_ff.num;
            emit_en        = 1'b1;
            emit_blk       = 1'b1;
            emit_woke      = woke_ff;
            emit_has       = 1'b1;
            emit_msg       = msg_ff;
         end
         S_RDREQ: begin
            thr_wr.queue_en = 1'b1;
            thr_wr.head     = head_inc;
            thr_wr.cnt      = rd_cnt - 1'b1;
            state_in        = S_RDDATA;
         end
         S_RDDATA: begin
            emit_en   = 1'b1;
            emit_has  = 1'b1;
            emit_msg  = ram_rdata;
            emit_last = flush_ff && (rd_cnt == '0);
         end
         S_OUT: begin
            if (rsp_acc) begin
               state_in = (flush_ff && (rd_cnt != '0)) ? S_RDREQ : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_en) begin
         state_in = S_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lim_ff       <= 4'd15;
         nsrc_ff      <= '0;
         nnum_ff      <= '0;
         nkind_ff     <= '0;
         for (int i = 0; i < tmbt_pkg::THREADS; i++) begin
            wf_ff[i]   <= 1'b0;
            wo_ff[i]   <= '0;
            aw_ff[i]   <= '0;
            open_ff[i] <= 1'b0;
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_acc) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               tmbt_pkg::REG_LIMIT:    lim_ff   <= csr_pwdata[3:0];
               tmbt_pkg::REG_NULL_SRC: nsrc_ff  <= csr_pwdata[3:0];
               tmbt_pkg::REG_NULL_NUM: nnum_ff  <= csr_pwdata[15:0];
               tmbt_pkg::REG_NULL_KND: nkind_ff <= csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
         if (thr_wr.wait_en) begin
            wf_ff[thr_wr.idx] <= thr_wr.wf;
            wo_ff[thr_wr.idx] <= thr_wr.wo;
            aw_ff[thr_wr.idx] <= thr_wr.aw;
         end
         if (thr_wr.open_en) begin
            open_ff[thr_wr.idx] <= thr_wr.open;
         end
         if (thr_wr.queue_en) begin
            head_ff[thr_wr.idx] <= thr_wr.head;
            cnt_ff[thr_wr.idx]  <= thr_wr.cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      steps_ff <= steps_in;
      flush_ff <= flush_in;
      woke_ff  <= woke_in;
      if (req_acc) begin
         func_ff        <= req_ch.func;
         s_ff           <= tmbt_pkg::thr_mod(req_ch.sender);
         t_ff           <= tmbt_pkg::thr_mod(req_ch.target);
         msg_ff.src     <= 4'(tmbt_pkg::thr_mod(req_ch.sender));
         msg_ff.num     <= req_ch.message_number;
         msg_ff.wants   <= req_ch.wants_reply;
         msg_ff.kind    <= req_ch.message_kind;
         msg_ff.payload <= req_ch.payload_handle;
      end
      if (emit_en) begin
         o_status_ff <= emit_status;
         o_blk_ff    <= emit_blk;
         o_woke_ff   <= emit_woke;
         o_has_ff    <= emit_has;
         o_last_ff   <= emit_last;
         o_msg_ff    <= emit_msg;
      end
   end

   tmbt_ram #(
      .WIDTH (tmbt_pkg::MSG_W),
      .DEPTH (tmbt_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (csr_paddr[3:2])
         tmbt_pkg::REG_LIMIT:    csr_prdata = 32'(lim_ff);
         tmbt_pkg::REG_NULL_SRC: csr_prdata = 32'(nsrc_ff);
         tmbt_pkg::REG_NULL_NUM: csr_prdata = 32'(nnum_ff);
         tmbt_pkg::REG_NULL_KND: csr_prdata = 32'(nkind_ff);
         default:                csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = o_status_ff;
   assign rsp_ch.sender_now_blocked = o_blk_ff;
   assign rsp_ch.target_woken       = o_woke_ff;
   assign rsp_ch.has_message        = o_has_ff;
   assign rsp_ch.out_source         = o_msg_ff.src;
   assign rsp_ch.out_number         = o_msg_ff.num;
   assign rsp_ch.out_wants_reply    = o_msg_ff.wants;
   assign rsp_ch.out_kind           = o_msg_ff.kind;
   assign rsp_ch.out_payload        = o_msg_ff.payload;
   assign rsp_ch.last               = o_last_ff;

endmodule
